// File: src/uirb_pkg.sv
// Shared types and constants for the UART ring buffer unit.
package uirb_pkg;

    typedef enum logic [3:0] {
        OP_RX     = 4'b0001,
        OP_TX_RDY = 4'b0010,
        OP_PUT    = 4'b0100,
        OP_GET    = 4'b1000
    } op_t;

    localparam logic [1:0] MODE_RX       = 2'd0;
    localparam logic [1:0] MODE_TX_READY = 2'd1;
    localparam logic [1:0] MODE_PUT      = 2'd2;
    localparam logic [1:0] MODE_GET      = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RX_FULL  = 2'd1;
    localparam logic [1:0] ST_TX_FULL  = 2'd2;
    localparam logic [1:0] ST_RX_EMPTY = 2'd3;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

// File: src/uirb_front.sv
// Front end: decodes incoming events and holds them in a two-entry queue.
module uirb_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          mode,
    input  logic [7:0]          data_byte,
    output logic                cmd_valid,
    output uirb_pkg::cmd_t      cmd,
    input  logic                cmd_take
);
    import uirb_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       cmd_in;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        unique case (mode)
            MODE_RX:       cmd_in.op = OP_RX;
            MODE_TX_READY: cmd_in.op = OP_TX_RDY;
            MODE_PUT:      cmd_in.op = OP_PUT;
            MODE_GET:      cmd_in.op = OP_GET;
        endcase
        cmd_in.data = data_byte;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// File: src/uirb_back.sv
// Back end: receive and transmit rings, transmitter flags and result register.
module uirb_back
#(
    parameter int RING_DEPTH = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  uirb_pkg::cmd_t      cmd,
    output logic                cmd_take,
    output logic                empty,
    input  logic                pop,
    output logic                line_valid,
    output logic [7:0]          line_byte,
    output logic                read_valid,
    output logic [7:0]          read_byte,
    output logic [1:0]          status,
    output logic                tx_irq_enabled,
    output logic                tx_active,
    output logic [7:0]          rx_level,
    output logic [7:0]          tx_level
);
    import uirb_pkg::*;

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(RING_DEPTH);

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_WAIT = 2'b10
    } state_t;

    logic [7:0]    rx_mem [RING_DEPTH];
    logic [7:0]    tx_mem [RING_DEPTH];
    logic [7:0]    rx_rd_reg;
    logic [7:0]    tx_rd_reg;

    state_t        state_reg, state_next;
    logic [PW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [PW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic [FW-1:0] rx_fill_reg, rx_fill_next, tx_fill_reg, tx_fill_next;
    logic          sending_reg, sending_next, irq_reg, irq_next;
    logic          pend_line_reg, pend_line_next, pend_read_reg, pend_read_next;

    logic          out_valid_reg, out_valid_next;
    logic          line_valid_reg, line_valid_next;
    logic [7:0]    line_byte_reg, line_byte_next;
    logic          read_valid_reg, read_valid_next;
    logic [7:0]    read_byte_reg, read_byte_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    rx_level_reg, rx_level_next;
    logic [7:0]    tx_level_reg, tx_level_next;
    logic          irq_out_reg, irq_out_next;
    logic          active_out_reg, active_out_next;

    logic          slot_free;
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [FW+7:0] rx_ext, tx_ext;

    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
        return (p == LAST_POS) ? '0 : p + PW'(1);
    endfunction

    assign slot_free = !out_valid_reg || pop;
    assign cmd_take  = (state_reg == S_EXEC) && cmd_valid && slot_free;
    assign rx_ext    = {8'd0, rx_fill_next};
    assign tx_ext    = {8'd0, tx_fill_next};

    always_comb
    begin
        state_next      = state_reg;
        rx_wp_next      = rx_wp_reg;
        rx_rp_next      = rx_rp_reg;
        tx_wp_next      = tx_wp_reg;
        tx_rp_next      = tx_rp_reg;
        rx_fill_next    = rx_fill_reg;
        tx_fill_next    = tx_fill_reg;
        sending_next    = sending_reg;
        irq_next        = irq_reg;
        pend_line_next  = pend_line_reg;
        pend_read_next  = pend_read_reg;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        out_valid_next  = out_valid_reg && !pop;
        line_valid_next = line_valid_reg;
        line_byte_next  = line_byte_reg;
        read_valid_next = read_valid_reg;
        read_byte_next  = read_byte_reg;
        status_next     = status_reg;
        rx_level_next   = rx_level_reg;
        tx_level_next   = tx_level_reg;
        irq_out_next    = irq_out_reg;
        active_out_next = active_out_reg;

        unique case (state_reg)
            S_EXEC:
            begin
                if (cmd_take)
                begin
                    line_valid_next = 1'b0;
                    line_byte_next  = 8'd0;
                    read_valid_next = 1'b0;
                    read_byte_next  = 8'd0;
                    status_next     = ST_OK;
                    pend_line_next  = 1'b0;
                    pend_read_next  = 1'b0;
                    unique case (cmd.op)
                        OP_RX:
                        begin
                            if (rx_fill_reg == FULL_CNT)
                            begin
                                status_next = ST_RX_FULL;
                            end
                            else
                            begin
                                rx_we        = 1'b1;
                                rx_wp_next   = adv(rx_wp_reg);
                                rx_fill_next = rx_fill_reg + FW'(1);
                            end
                        end
                        OP_TX_RDY:
                        begin
                            if (tx_fill_reg == '0)
                            begin
                                irq_next     = 1'b0;
                                sending_next = 1'b0;
                            end
                            else
                            begin
                                tx_re          = 1'b1;
                                tx_rp_next     = adv(tx_rp_reg);
                                tx_fill_next   = tx_fill_reg - FW'(1);
                                pend_line_next = 1'b1;
                            end
                        end
                        OP_PUT:
                        begin
                            if (sending_reg)
                            begin
                                if (tx_fill_reg == FULL_CNT)
                                begin
                                    status_next = ST_TX_FULL;
                                end
                                else
                                begin
                                    tx_we        = 1'b1;
                                    tx_wp_next   = adv(tx_wp_reg);
                                    tx_fill_next = tx_fill_reg + FW'(1);
                                end
                            end
                            else
                            begin
                                line_valid_next = 1'b1;
                                line_byte_next  = cmd.data;
                                irq_next        = 1'b1;
                                sending_next    = 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (rx_fill_reg == '0)
                            begin
                                status_next = ST_RX_EMPTY;
                            end
                            else
                            begin
                                rx_re          = 1'b1;
                                rx_rp_next     = adv(rx_rp_reg);
                                rx_fill_next   = rx_fill_reg - FW'(1);
                                pend_read_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    rx_level_next   = rx_ext[7:0];
                    tx_level_next   = tx_ext[7:0];
                    irq_out_next    = irq_next;
                    active_out_next = sending_next;
                    if (rx_re || tx_re)
                    begin
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_WAIT:
            begin
                line_valid_next = pend_line_reg;
                line_byte_next  = pend_line_reg ? tx_rd_reg : 8'd0;
                read_valid_next = pend_read_reg;
                read_byte_next  = pend_read_reg ? rx_rd_reg : 8'd0;
                out_valid_next  = 1'b1;
                state_next      = S_EXEC;
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            rx_fill_reg   <= '0;
            tx_fill_reg   <= '0;
            sending_reg   <= 1'b0;
            irq_reg       <= 1'b0;
            pend_line_reg <= 1'b0;
            pend_read_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rx_wp_reg     <= rx_wp_next;
            rx_rp_reg     <= rx_rp_next;
            tx_wp_reg     <= tx_wp_next;
            tx_rp_reg     <= tx_rp_next;
            rx_fill_reg   <= rx_fill_next;
            tx_fill_reg   <= tx_fill_next;
            sending_reg   <= sending_next;
            irq_reg       <= irq_next;
            pend_line_reg <= pend_line_next;
            pend_read_reg <= pend_read_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_valid_reg <= line_valid_next;
        line_byte_reg  <= line_byte_next;
        read_valid_reg <= read_valid_next;
        read_byte_reg  <= read_byte_next;
        status_reg     <= status_next;
        rx_level_reg   <= rx_level_next;
        tx_level_reg   <= tx_level_next;
        irq_out_reg    <= irq_out_next;
        active_out_reg <= active_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_wp_reg] <= cmd.data;
        end
        if (rx_re)
        begin
            rx_rd_reg <= rx_mem[rx_rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_wp_reg] <= cmd.data;
        end
        if (tx_re)
        begin
            tx_rd_reg <= tx_mem[tx_rp_reg];
        end
    end

    assign empty          = !out_valid_reg;
    assign line_valid     = line_valid_reg;
    assign line_byte      = line_byte_reg;
    assign read_valid     = read_valid_reg;
    assign read_byte      = read_byte_reg;
    assign status         = status_reg;
    assign tx_irq_enabled = irq_out_reg;
    assign tx_active      = active_out_reg;
    assign rx_level       = rx_level_reg;
    assign tx_level       = tx_level_reg;

endmodule

// File: src/interrupt_uart_ring_buffers_unit.sv
// Top level of the interrupt-driven UART ring buffer unit.
//
// Requests enter through push/full carrying mode and data_byte: received
// byte, transmitter-ready interrupt, software put or software get. Every
// request yields exactly one result, offered on the result ports while
// empty is low and taken with pop.
// A request is decoded by the front end and held in a two-entry queue
// until the back end takes it. Requests that touch no ring entry for
// reading write their result straight into the output register when
// taken. A ring pop (interrupt with bytes queued, get with bytes
// received) first does a registered ring read in a wait state, then
// writes the result, and the back end takes no new request meanwhile.
// Sustained rate: one request per cycle while pop is high and no ring pop waits.
// A result waits in the output register while pop is low; the back end
// also stalls when a new result would overwrite it, and push keeps
// filling the queue until full rises.
// Reset clears pointers, fill counts, flags, queue and the result valid flag;
// the result fields and the ring storage need no clearing.
module interrupt_uart_ring_buffers_unit
#(
    parameter int RING_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] mode,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic       line_valid,
    output logic [7:0] line_byte,
    output logic       read_valid,
    output logic [7:0] read_byte,
    output logic [1:0] status,
    output logic       tx_irq_enabled,
    output logic       tx_active,
    output logic [7:0] rx_level,
    output logic [7:0] tx_level
);
    import uirb_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    uirb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    uirb_back #(.RING_DEPTH(RING_DEPTH)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .empty          (empty),
        .pop            (pop),
        .line_valid     (line_valid),
        .line_byte      (line_byte),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .status         (status),
        .tx_irq_enabled (tx_irq_enabled),
        .tx_active      (tx_active),
        .rx_level       (rx_level),
        .tx_level       (tx_level)
    );

endmodule

// File: src/uirb_checker.sv
// Port-level checks for the UART ring buffer unit and their binding.
module uirb_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  logic       pop,
    input  logic       line_valid,
    input  logic       read_valid,
    input  logic [7:0] read_byte,
    input  logic [1:0] status,
    input  logic       tx_irq_enabled,
    input  logic       tx_active
);
    import uirb_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(line_valid && read_valid))
        else $error("line and read results in one request");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (tx_irq_enabled == tx_active))
        else $error("interrupt enable and transmitter flag disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && read_valid) |-> (status == ST_OK))
        else $error("returned byte with error status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(read_byte) && $stable(status)))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !read_valid) |-> (read_byte == 8'd0))
        else $error("read byte set without a returned byte");

endmodule

bind interrupt_uart_ring_buffers_unit uirb_checker u_uirb_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .line_valid     (line_valid),
    .read_valid     (read_valid),
    .read_byte      (read_byte),
    .status         (status),
    .tx_irq_enabled (tx_irq_enabled),
    .tx_active      (tx_active)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UART ring buffer unit: ring traffic, overflow and back-pressure.
module testbench;
    import uirb_pkg::*;

    localparam int RING_DEPTH  = 128;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQS = 150;
    localparam int CHUNK_REQS  = 50;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       tx_irq_enabled;
        logic       tx_active;
        logic [7:0] rx_level;
        logic [7:0] tx_level;
    } uart_outcome_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [1:0] mode = MODE_RX;
    logic [7:0] data_byte = 8'h00;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic       tx_irq_enabled;
    logic       tx_active;
    logic [7:0] rx_level;
    logic [7:0] tx_level;

    // Predicted ring state
    logic [7:0] rx_ring [RING_DEPTH];
    logic [7:0] tx_ring [RING_DEPTH];
    int         rx_wr = 0;
    int         rx_rd = 0;
    int         rx_count = 0;
    int         tx_wr = 0;
    int         tx_rd = 0;
    int         tx_count = 0;
    logic       tx_on = 1'b0;
    logic       irq_on = 1'b0;

    uart_outcome_t pending_outcomes[$];

    logic gaps_on = 1'b1;
    logic hold_on = 1'b0;
    int   hold_cycles = 0;
    event hold_start;

    int cycle_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int rx_drops = 0;
    int tx_drops = 0;
    int empty_gets = 0;

    interrupt_uart_ring_buffers_unit #(
        .RING_DEPTH(RING_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .mode(mode),
        .data_byte(data_byte),
        .empty(empty),
        .pop(pop),
        .line_valid(line_valid),
        .line_byte(line_byte),
        .read_valid(read_valid),
        .read_byte(read_byte),
        .status(status),
        .tx_irq_enabled(tx_irq_enabled),
        .tx_active(tx_active),
        .rx_level(rx_level),
        .tx_level(tx_level)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic predict_outcome(input logic [1:0] m, input logic [7:0] d);
        uart_outcome_t o;
        o = '0;
        o.status = ST_OK;
        case (m)
            MODE_RX:
            begin
                if (rx_count >= RING_DEPTH)
                begin
                    o.status = ST_RX_FULL;
                    rx_drops++;
                end
                else
                begin
                    rx_ring[rx_wr] = d;
                    rx_wr = (rx_wr + 1) % RING_DEPTH;
                    rx_count++;
                end
            end
            MODE_TX_READY:
            begin
                if (tx_count == 0)
                begin
                    irq_on = 1'b0;
                    tx_on  = 1'b0;
                end
                else
                begin
                    o.line_valid = 1'b1;
                    o.line_byte  = tx_ring[tx_rd];
                    tx_rd = (tx_rd + 1) % RING_DEPTH;
                    tx_count--;
                end
            end
            MODE_PUT:
            begin
                if (!tx_on)
                begin
                    o.line_valid = 1'b1;
                    o.line_byte  = d;
                    irq_on = 1'b1;
                    tx_on  = 1'b1;
                end
                else if (tx_count >= RING_DEPTH)
                begin
                    o.status = ST_TX_FULL;
                    tx_drops++;
                end
                else
                begin
                    tx_ring[tx_wr] = d;
                    tx_wr = (tx_wr + 1) % RING_DEPTH;
                    tx_count++;
                end
            end
            MODE_GET:
            begin
                if (rx_count == 0)
                begin
                    o.status = ST_RX_EMPTY;
                    empty_gets++;
                end
                else
                begin
                    o.read_valid = 1'b1;
                    o.read_byte  = rx_ring[rx_rd];
                    rx_rd = (rx_rd + 1) % RING_DEPTH;
                    rx_count--;
                end
            end
        endcase
        o.tx_irq_enabled = irq_on;
        o.tx_active      = tx_on;
        o.rx_level       = rx_count[7:0];
        o.tx_level       = tx_count[7:0];
        pending_outcomes.push_back(o);
    endtask

    task automatic send_request(input logic [1:0] m, input logic [7:0] d);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        mode      <= m;
        data_byte <= d;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_outcome(m, d);
        requests_sent++;
    endtask

    function automatic logic [1:0] pick_mode(input int w_rx, input int w_rdy,
                                             input int w_put, input int w_get);
        int r;
        r = $urandom_range(0, w_rx + w_rdy + w_put + w_get - 1);
        if (r < w_rx)
            return MODE_RX;
        if (r < w_rx + w_rdy)
            return MODE_TX_READY;
        if (r < w_rx + w_rdy + w_put)
            return MODE_PUT;
        return MODE_GET;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch at result %0d: %s", results_checked, msg);
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
            flag_mismatch($sformatf("%s expected %0d, got %0d", name, want_v, got_v));
    endtask

    initial
    begin : receiver_hold
        forever
        begin
            @(hold_start);
            hold_on <= 1'b1;
            repeat (hold_cycles) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    initial
    begin : result_checker
        uart_outcome_t seen;
        uart_outcome_t want;
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 4) : 0;
            if (stall > 0 || hold_on)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_on)
                    @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            seen = {line_valid, line_byte, read_valid, read_byte, status,
                    tx_irq_enabled, tx_active, rx_level, tx_level};
            if (pending_outcomes.size() == 0)
                flag_mismatch("result with no request waiting");
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("line_valid", want.line_valid, seen.line_valid);
                check_field("line_byte", want.line_byte, seen.line_byte);
                check_field("read_valid", want.read_valid, seen.read_valid);
                check_field("read_byte", want.read_byte, seen.read_byte);
                check_field("status", want.status, seen.status);
                check_field("tx_irq_enabled", want.tx_irq_enabled, seen.tx_irq_enabled);
                check_field("tx_active", want.tx_active, seen.tx_active);
                check_field("rx_level", want.rx_level, seen.rx_level);
                check_field("tx_level", want.tx_level, seen.tx_level);
            end
            results_checked++;
        end
    end

    task automatic test_directed();
        gaps_on = 1'b1;
        // ready interrupt with the interrupt disabled and nothing queued
        send_request(MODE_TX_READY, 8'h5A);
        send_request(MODE_GET, 8'hFF);
        send_request(MODE_RX, 8'h00);
        send_request(MODE_RX, 8'hFF);
        send_request(MODE_RX, 8'hA5);
        send_request(MODE_GET, 8'h00);
        send_request(MODE_GET, 8'h00);
        send_request(MODE_GET, 8'h00);
        send_request(MODE_GET, 8'h5A);
        // transmitter off: byte goes straight to the line
        send_request(MODE_PUT, 8'hFF);
        send_request(MODE_PUT, 8'h00);
        send_request(MODE_PUT, 8'h5A);
        send_request(MODE_TX_READY, 8'hFF);
        send_request(MODE_TX_READY, 8'h00);
        send_request(MODE_TX_READY, 8'h00);
        send_request(MODE_PUT, 8'h81);
        send_request(MODE_TX_READY, 8'hC3);
    endtask

    task automatic test_rx_overflow();
        while (rx_count < RING_DEPTH)
            send_request(MODE_RX, 8'($urandom_range(0, 255)));
        repeat (3) send_request(MODE_RX, 8'($urandom_range(0, 255)));
        while (rx_count > 0)
            send_request(MODE_GET, 8'($urandom_range(0, 255)));
        send_request(MODE_GET, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_tx_overflow();
        if (!tx_on)
            send_request(MODE_PUT, 8'($urandom_range(0, 255)));
        while (tx_count < RING_DEPTH)
            send_request(MODE_PUT, 8'($urandom_range(0, 255)));
        repeat (3) send_request(MODE_PUT, 8'($urandom_range(0, 255)));
        while (tx_count > 0)
            send_request(MODE_TX_READY, 8'($urandom_range(0, 255)));
        send_request(MODE_TX_READY, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_cycles = HOLD_CYCLES;
        -> hold_start;
        repeat (40) send_request(pick_mode(1, 1, 1, 1), 8'($urandom_range(0, 255)));
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int w_rx;
        int w_rdy;
        int w_put;
        int w_get;
        for (int chunk = 0; chunk < RANDOM_REQS / CHUNK_REQS; chunk++)
        begin
            w_rx  = $urandom_range(1, 4);
            w_rdy = $urandom_range(1, 4);
            w_put = $urandom_range(1, 4);
            w_get = $urandom_range(1, 4);
            gaps_on = (chunk % 4 != 3);
            repeat (CHUNK_REQS)
                send_request(pick_mode(w_rx, w_rdy, w_put, w_get),
                             8'($urandom_range(0, 255)));
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin : main_sequence
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_rx_overflow();
        test_tx_overflow();
        test_backpressure();
        test_random_traffic();
        push <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d requests, checked %0d results, %0d mismatches.",
                 requests_sent, results_checked, mismatch_count);
        $display("Covered %0d receive drops, %0d transmit drops, %0d empty gets %s",
                 rx_drops, tx_drops, empty_gets, "and a held result path.");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
